### src/pzh_pkg.sv
// ----------------------------------------------------------------------------
// pzh_pkg
// Shared types and constants for the proximity zone hysteresis block.
// ----------------------------------------------------------------------------
`default_nettype none

package pzh_pkg;

  // Zone count and zone order: front slow, front stop, rear slow, rear stop
  localparam int unsigned NumZones = 4;
  localparam int unsigned ZoneFrontSlow = 0;
  localparam int unsigned ZoneFrontStop = 1;
  localparam int unsigned ZoneRearSlow  = 2;
  localparam int unsigned ZoneRearStop  = 3;

  // Release hold in milliseconds
  localparam logic [31:0] HoldMs = 32'd500;

  // Configuration port geometry
  localparam int unsigned NumRegs   = 8;
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  // Register indexes
  typedef enum logic [2:0] {
    REG_FRONT_SLOW_ENTER = 3'd0,
    REG_FRONT_SLOW_EXIT  = 3'd1,
    REG_FRONT_STOP_ENTER = 3'd2,
    REG_FRONT_STOP_EXIT  = 3'd3,
    REG_REAR_SLOW_ENTER  = 3'd4,
    REG_REAR_SLOW_EXIT   = 3'd5,
    REG_REAR_STOP_ENTER  = 3'd6,
    REG_REAR_STOP_EXIT   = 3'd7
  } reg_idx_t;

  // Register reset values, in register order
  localparam logic [15:0] RegReset [NumRegs] = '{
    16'd40, 16'd50, 16'd20, 16'd25, 16'd40, 16'd50, 16'd20, 16'd25
  };

  // Thresholds of one zone
  typedef struct packed {
    logic [15:0] enter;
    logic [15:0] leave;
  } zone_thr_t;

  typedef zone_thr_t [NumZones-1:0] zone_thr_vec_t;

  // Input transaction
  typedef struct packed {
    logic [15:0] front_distance;
    logic [15:0] rear_distance;
    logic [31:0] now_ms;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [15:0] front_distance_out;
    logic        front_slow_active;
    logic        front_stop_active;
    logic [15:0] rear_distance_out;
    logic        rear_slow_active;
    logic        rear_stop_active;
  } out_item_t;

endpackage

`default_nettype wire

### src/pzh_cfg_regs.sv
// ----------------------------------------------------------------------------
// pzh_cfg_regs
// APB-style threshold register file; hands per-zone thresholds to the lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module pzh_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [pzh_pkg::AddrWidth-1:0]     cfg_paddr,
  input  wire logic [pzh_pkg::DataWidth-1:0]     cfg_pwdata,
  output logic      [pzh_pkg::DataWidth-1:0]     cfg_prdata,
  output logic                                   cfg_pready,
  output pzh_pkg::zone_thr_vec_t                 thr
);

  logic [15:0] regs_r [pzh_pkg::NumRegs];
  logic [2:0]  idx;
  logic        wr_en;

  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  // Register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= pzh_pkg::RegReset;
    end else if (wr_en) begin
      regs_r[idx] <= cfg_pwdata[15:0];
    end
  end

  // Read back
  assign cfg_prdata = {16'd0, regs_r[idx]};

  // Zone threshold mapping
  assign thr[pzh_pkg::ZoneFrontSlow].enter = regs_r[pzh_pkg::REG_FRONT_SLOW_ENTER];
  assign thr[pzh_pkg::ZoneFrontSlow].leave = regs_r[pzh_pkg::REG_FRONT_SLOW_EXIT];
  assign thr[pzh_pkg::ZoneFrontStop].enter = regs_r[pzh_pkg::REG_FRONT_STOP_ENTER];
  assign thr[pzh_pkg::ZoneFrontStop].leave = regs_r[pzh_pkg::REG_FRONT_STOP_EXIT];
  assign thr[pzh_pkg::ZoneRearSlow].enter  = regs_r[pzh_pkg::REG_REAR_SLOW_ENTER];
  assign thr[pzh_pkg::ZoneRearSlow].leave  = regs_r[pzh_pkg::REG_REAR_SLOW_EXIT];
  assign thr[pzh_pkg::ZoneRearStop].enter  = regs_r[pzh_pkg::REG_REAR_STOP_ENTER];
  assign thr[pzh_pkg::ZoneRearStop].leave  = regs_r[pzh_pkg::REG_REAR_STOP_EXIT];

endmodule

`default_nettype wire

### src/pzh_zone_lane.sv
// ----------------------------------------------------------------------------
// pzh_zone_lane
// One zone: hysteresis compare with release hold; keeps flag and start time.
// ----------------------------------------------------------------------------
`default_nettype none

module pzh_zone_lane (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              upd,
  input  wire logic [15:0]       range_cm,
  input  wire pzh_pkg::zone_thr_t thr,
  input  wire logic [31:0]       now_ms,
  output logic                   flag_nxt
);

  logic        flag_r;
  logic [31:0] ts_r;
  logic [31:0] ts_nxt;
  logic [31:0] ts_start;
  logic [31:0] elapsed;
  logic        hit_enter;
  logic        hit_exit;

  // Threshold compares; a zero reading is ignored
  assign hit_enter = (range_cm != 16'd0) && (range_cm <= thr.enter);
  assign hit_exit  = (range_cm != 16'd0) && !hit_enter && (range_cm > thr.leave) && flag_r;

  // Zero start time means not started
  assign ts_start = (ts_r == 32'd0) ? now_ms : ts_r;
  assign elapsed  = now_ms - ts_start;

  always_comb begin
    flag_nxt = flag_r;
    ts_nxt   = ts_r;
    if (hit_enter) begin
      flag_nxt = 1'b1;
      ts_nxt   = 32'd0;
    end else if (hit_exit) begin
      ts_nxt = ts_start;
      if (elapsed >= pzh_pkg::HoldMs) begin
        flag_nxt = 1'b0;
      end
    end
  end

  // State update on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
      ts_r   <= 32'd0;
    end else if (upd) begin
      flag_r <= flag_nxt;
      ts_r   <= ts_nxt;
    end
  end

endmodule

`default_nettype wire

### src/pzh_merge.sv
// ----------------------------------------------------------------------------
// pzh_merge
// Gathers the lane flags with the readings into the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module pzh_merge (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             take,
  input  wire pzh_pkg::in_item_t                item,
  input  wire logic [pzh_pkg::NumZones-1:0]     flags,
  input  wire logic                             out_stall,
  output logic                                  out_valid,
  output pzh_pkg::out_item_t                    out_data
);

  logic               out_valid_r;
  pzh_pkg::out_item_t out_data_r;
  pzh_pkg::out_item_t out_data_nxt;

  // Pack the result
  always_comb begin
    out_data_nxt.front_distance_out = item.front_distance;
    out_data_nxt.front_slow_active  = flags[pzh_pkg::ZoneFrontSlow];
    out_data_nxt.front_stop_active  = flags[pzh_pkg::ZoneFrontStop];
    out_data_nxt.rear_distance_out  = item.rear_distance;
    out_data_nxt.rear_slow_active   = flags[pzh_pkg::ZoneRearSlow];
    out_data_nxt.rear_stop_active   = flags[pzh_pkg::ZoneRearStop];
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### src/proximity_zone_hysteresis_top.sv
// ----------------------------------------------------------------------------
// proximity_zone_hysteresis_top
// Four-zone proximity hysteresis with release hold, one lane per zone.
//
//   Channel  Ports                             Transaction
//   in       in_valid, in_stall, in_data       front/rear reading and time
//   out      out_valid, out_stall, out_data    readings and four zone flags
//   cfg      cfg_psel .. cfg_pready            threshold write/read (APB)
//
// One transaction per cycle unless in_stall is raised; the result appears in the
// cycle after acceptance, set by the single output register behind the four zone lanes.
// Synchronous active-low reset clears zone state and loads threshold defaults.
// in_stall is raised only while a held result is stalled downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module proximity_zone_hysteresis_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire pzh_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output pzh_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [pzh_pkg::AddrWidth-1:0]  cfg_paddr,
  input  wire logic [pzh_pkg::DataWidth-1:0]  cfg_pwdata,
  output logic      [pzh_pkg::DataWidth-1:0]  cfg_prdata,
  output logic                                cfg_pready
);

  pzh_pkg::zone_thr_vec_t           thr;
  logic [pzh_pkg::NumZones-1:0]     flags;
  logic                             take;

  // Handshake: accept unless a result is held and stalled
  assign in_stall = out_valid & out_stall;
  assign take     = in_valid & ~in_stall;

  pzh_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .thr         (thr)
  );

  // Zone lanes: first two on the front reading, last two on the rear
  for (genvar z = 0; z < pzh_pkg::NumZones; z++) begin : g_lane
    logic [15:0] lane_range;
    assign lane_range = (z < pzh_pkg::ZoneRearSlow) ? in_data.front_distance
                                                    : in_data.rear_distance;
    pzh_zone_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .upd      (take),
      .range_cm (lane_range),
      .thr      (thr[z]),
      .now_ms   (in_data.now_ms),
      .flag_nxt (flags[z])
    );
  end

  pzh_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (in_data),
    .flags     (flags),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
